[rtl/gmcp_pkg.sv]
`timescale 1ns / 1ps
package gmcp_pkg;
  localparam int MaxSide  = 128;
  localparam int Cells    = MaxSide * MaxSide;
  localparam int IdxW     = $clog2(Cells);
  localparam int SideW    = $clog2(MaxSide + 1);
  localparam int CoordW   = $clog2(MaxSide);
  localparam int CostW    = 12;
  localparam int WeightW  = 4;
  localparam logic [CostW-1:0] CostMax = '1;

  // Search engine to store requests
  typedef struct packed {
    logic             cost_we;
    logic [IdxW-1:0]  cost_addr;
    logic [CostW-1:0] cost_wdata;
    logic             flag_we;
    logic [IdxW-1:0]  flag_addr;
    logic             flag_wdata;
    logic             ring_we;
    logic [IdxW-1:0]  ring_addr;
    logic [IdxW-1:0]  ring_wdata;
  } store_wr_t;
endpackage

[rtl/gmcp_ram.sv]
`timescale 1ns / 1ps
module gmcp_ram #(
  parameter int Depth = 16,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[rtl/gmcp_search.sv]
`timescale 1ns / 1ps
module gmcp_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [gmcp_pkg::SideW-1:0]    side_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [gmcp_pkg::CostW-1:0]    cost_o,
  output logic [gmcp_pkg::IdxW-1:0]     w_raddr_o,
  input  logic [gmcp_pkg::WeightW-1:0]  w_rdata_i
);
  import gmcp_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StClear = 4'd1;
  localparam logic [3:0] StPop   = 4'd2;
  localparam logic [3:0] StCur   = 4'd3;
  localparam logic [3:0] StNbr   = 4'd4;
  localparam logic [3:0] StRead  = 4'd5;
  localparam logic [3:0] StRelax = 4'd6;
  localparam logic [3:0] StFinA  = 4'd7;
  localparam logic [3:0] StFinB  = 4'd8;

  logic [3:0] st_q, st_d;
  logic [IdxW-1:0] clr_q, clr_d, head_q, head_d, tail_q, tail_d;
  logic [IdxW-1:0] cur_q, cur_d, nb_q, nb_d;
  logic [CoordW-1:0] r_q, r_d, c_q, c_d;
  logic [1:0] k_q, k_d;
  logic [CostW-1:0] cc_q, cc_d, res_q, res_d;
  logic done_q, done_d;
  logic [IdxW-1:0] w_row_base;

  store_wr_t wr;
  logic [IdxW-1:0] cost_ra, flag_ra, ring_ra;
  logic [CostW-1:0] cost_rd;
  logic flag_rd;
  logic [IdxW-1:0] ring_rd;

  gmcp_ram #(.Depth(Cells), .Width(CostW)) u_cost (
    .clk_i, .we_i(wr.cost_we), .waddr_i(wr.cost_addr), .wdata_i(wr.cost_wdata),
    .raddr_i(cost_ra), .rdata_o(cost_rd));
  gmcp_ram #(.Depth(Cells), .Width(1)) u_flag (
    .clk_i, .we_i(wr.flag_we), .waddr_i(wr.flag_addr), .wdata_i(wr.flag_wdata),
    .raddr_i(flag_ra), .rdata_o(flag_rd));
  gmcp_ram #(.Depth(Cells), .Width(IdxW)) u_ring (
    .clk_i, .we_i(wr.ring_we), .waddr_i(wr.ring_addr), .wdata_i(wr.ring_wdata),
    .raddr_i(ring_ra), .rdata_o(ring_rd));

  // weights sit at the linear load index row*side+col; read from registered nb
  assign w_row_base = IdxW'(nb_q[IdxW-1 -: CoordW]) * IdxW'(side_i);
  assign w_raddr_o = w_row_base + IdxW'(nb_q[CoordW-1:0]);

  logic nb_ok;
  logic [CostW:0] cand;
  logic [CoordW:0] side_m1;

  always_comb begin
    side_m1 = (CoordW+1)'(side_i - 1'b1);
    nb_ok = 1'b0;
    nb_d = nb_q;
    // neighbor order: down, up, right, left; rows are MaxSide apart in store
    case (k_q)
      2'd0: begin
        nb_ok = {1'b0, r_q} < side_m1;
        nb_d = cur_q + IdxW'(MaxSide);
      end
      2'd1: begin
        nb_ok = r_q != '0;
        nb_d = cur_q - IdxW'(MaxSide);
      end
      2'd2: begin
        nb_ok = {1'b0, c_q} < side_m1;
        nb_d = cur_q + IdxW'(1);
      end
      default: begin
        nb_ok = c_q != '0;
        nb_d = cur_q - IdxW'(1);
      end
    endcase
  end

  assign cand = {1'b0, cc_q} + (CostW+1)'(w_rdata_i);

  always_comb begin
    st_d = st_q; clr_d = clr_q; head_d = head_q; tail_d = tail_q;
    cur_d = cur_q; r_d = r_q; c_d = c_q; k_d = k_q; cc_d = cc_q;
    res_d = res_q; done_d = 1'b0;
    wr = '0;
    cost_ra = nb_q; flag_ra = nb_q; ring_ra = head_q;
    unique case (st_q)
      StIdle: begin
        if (start_i) begin
          st_d = StClear;
          clr_d = '0;
        end
      end
      StClear: begin
        wr.cost_we = 1'b1; wr.cost_addr = clr_q;
        wr.cost_wdata = (clr_q == '0) ? '0 : CostMax;
        wr.flag_we = 1'b1; wr.flag_addr = clr_q; wr.flag_wdata = (clr_q == '0);
        clr_d = clr_q + 1'b1;
        if (clr_q == IdxW'(Cells - 1)) begin
          wr.ring_we = 1'b1; wr.ring_addr = '0; wr.ring_wdata = '0;
          head_d = '0; tail_d = IdxW'(1);
          st_d = StPop;
        end
      end
      StPop: begin
        if (head_q == tail_q) begin
          st_d = StFinA;
        end else begin
          ring_ra = head_q;
          st_d = StCur;
        end
      end
      StCur: begin
        // ring data valid; fetch its cost next
        cur_d = ring_rd;
        r_d = ring_rd[IdxW-1 -: CoordW];
        c_d = ring_rd[CoordW-1:0];
        cost_ra = ring_rd;
        head_d = head_q + 1'b1;
        wr.flag_we = 1'b1; wr.flag_addr = ring_rd; wr.flag_wdata = 1'b0;
        k_d = 2'd0;
        st_d = StNbr;
      end
      StNbr: begin
        if (k_q == 2'd0) cc_d = cost_rd;
        if (nb_ok) begin
          cost_ra = nb_d; flag_ra = nb_d;
          st_d = StRead;
        end else if (k_q == 2'd3) begin
          st_d = StPop;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      StRead: begin
        st_d = StRelax;
      end
      StRelax: begin
        if (cand < {1'b0, cost_rd}) begin
          wr.cost_we = 1'b1; wr.cost_addr = nb_q; wr.cost_wdata = cand[CostW-1:0];
          if (!flag_rd) begin
            wr.flag_we = 1'b1; wr.flag_addr = nb_q; wr.flag_wdata = 1'b1;
            wr.ring_we = 1'b1; wr.ring_addr = tail_q; wr.ring_wdata = nb_q;
            tail_d = tail_q + 1'b1;
          end
        end
        if (k_q == 2'd3) begin
          st_d = StPop;
        end else begin
          k_d = k_q + 1'b1;
          st_d = StNbr;
        end
      end
      StFinA: begin
        // bottom-right cell at row side-1, col side-1
        cost_ra = {side_m1[CoordW-1:0], side_m1[CoordW-1:0]};
        st_d = StFinB;
      end
      StFinB: begin
        res_d = cost_rd;
        done_d = 1'b1;
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  // nb register follows its selection only while stepping neighbors
  logic [IdxW-1:0] nb_n;
  assign nb_n = (st_q == StNbr) ? nb_d : nb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; head_q <= '0; tail_q <= '0; done_q <= 1'b0;
    end else begin
      st_q <= st_d; head_q <= head_d; tail_q <= tail_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    clr_q <= clr_d; cur_q <= cur_d; r_q <= r_d; c_q <= c_d; k_q <= k_d;
    cc_q <= cc_d; res_q <= res_d; nb_q <= nb_n;
  end

  assign busy_o = st_q != StIdle;
  assign done_o = done_q;
  assign cost_o = res_q;
endmodule

[rtl/grid_min_cost_path_top.sv]
`timescale 1ns / 1ps
// Least-cost 4-neighbor path across a square grid.
// Input channel: cell_weight_i / last_cell_i with in_valid_i, in_stall_o.
//   A request is accepted when in_valid_i is high and in_stall_o low.
//   Cells arrive in row-major order; last_cell_i starts the search.
// Output channel: path_cost_o with out_valid_o, out_stall_i; one result
//   per grid, held in an output register until taken.
// Config: grid_side written by cfg_we_i / cfg_wdata_i while idle
//   (0 acts as 1, above 128 acts as 128). Reset value 128.
// Loading accepts one cell per cycle while not stalled. The search then
//   clears the cost and queued-flag memories; for each dequeued cell it
//   pops the ring, reads the cell's cost and steps its neighbors, skipping
//   border sides and reading cost, flag and weight of each in-grid one
//   (registered memory reads) to relax it. When the queue empties the
//   bottom-right cost becomes the result. Input stalls for the whole search.
// Weights sit at the linear load index (wrapping at 16384); the search keeps
//   costs at row*128+col and forms row*side+col for each weight read.
// Reset clears FSM, queue and port registers; weights undefined until written.
// A finished result waits in its register while stalled; input stays
//   stalled until the result is taken.
module grid_min_cost_path_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [3:0]                    cell_weight_i,
  input  logic                          last_cell_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [11:0]                   path_cost_o,
  input  logic                          cfg_we_i,
  input  logic [7:0]                    cfg_wdata_i
);
  import gmcp_pkg::*;

  logic [7:0] side_raw_q;
  logic [SideW-1:0] side;
  logic [IdxW-1:0] lin_q;
  logic out_v_q;
  logic [CostW-1:0] out_q;
  logic busy, done, start, accept;
  logic [CostW-1:0] cost;
  logic [IdxW-1:0] w_raddr, w_waddr;
  logic [WeightW-1:0] w_rdata;

  always_comb begin
    if (side_raw_q == 8'd0) side = SideW'(1);
    else if (side_raw_q > 8'(MaxSide)) side = SideW'(MaxSide);
    else side = SideW'(side_raw_q);
  end

  // done also stalls: the result register is loaded on that cycle
  assign in_stall_o = busy || done || out_v_q;
  assign accept = in_valid_i && !in_stall_o;
  assign start = accept && last_cell_i;
  assign w_waddr = lin_q;

  gmcp_ram #(.Depth(Cells), .Width(WeightW)) u_weight (
    .clk_i, .we_i(accept), .waddr_i(w_waddr), .wdata_i(cell_weight_i),
    .raddr_i(w_raddr), .rdata_o(w_rdata));

  gmcp_search u_search (
    .clk_i, .rst_ni, .start_i(start), .side_i(side), .busy_o(busy),
    .done_o(done), .cost_o(cost), .w_raddr_o(w_raddr), .w_rdata_i(w_rdata));

  // load address: linear count, restarts per grid, wraps round the store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_raw_q <= 8'd128;
      lin_q <= '0;
      out_v_q <= 1'b0; out_q <= '0;
    end else begin
      if (cfg_we_i) side_raw_q <= cfg_wdata_i;
      if (accept) begin
        if (last_cell_i) begin
          lin_q <= '0;
        end else begin
          lin_q <= lin_q + 1'b1;
        end
      end
      if (done) begin
        out_v_q <= 1'b1; out_q <= cost;
      end else if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign path_cost_o = out_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !accept) else $error("request accepted during search");
  a_done_sets_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> out_v_q) else $error("result lost");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> busy) else $error("search did not start");
endmodule
